// File: rtl/core/swsr_pkg.sv
`default_nettype none

package swsr_pkg;

    // command codes carried on the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // line driver codes
    localparam logic [1:0] LINE_RELEASE    = 2'd0;
    localparam logic [1:0] LINE_DRIVE_LOW  = 2'd1;
    localparam logic [1:0] LINE_DRIVE_HIGH = 2'd2;

    // register indexes (byte address is 4 * index)
    localparam int          REG_IDX_W          = 3;
    localparam logic [2:0]  REG_START_LOW      = 3'd0;
    localparam logic [2:0]  REG_START_HIGH     = 3'd1;
    localparam logic [2:0]  REG_ANSWER_WAIT    = 3'd2;
    localparam logic [2:0]  REG_ANSWER_CHECK   = 3'd3;
    localparam logic [2:0]  REG_BIT_SAMPLE     = 3'd4;
    localparam logic [2:0]  REG_EDGE_TIMEOUT   = 3'd5;

    // register reset values in microseconds
    localparam logic [15:0] START_LOW_RST      = 16'd1300;
    localparam logic [15:0] START_HIGH_RST     = 16'd30;
    localparam logic [15:0] ANSWER_WAIT_RST    = 16'd40;
    localparam logic [15:0] ANSWER_CHECK_RST   = 16'd80;
    localparam logic [15:0] BIT_SAMPLE_RST     = 16'd40;
    localparam logic [15:0] EDGE_TIMEOUT_RST   = 16'd2000;

    typedef struct packed {
        logic [15:0] start_low_time;
        logic [15:0] start_high_time;
        logic [15:0] answer_wait_time;
        logic [15:0] answer_check_time;
        logic [15:0] bit_sample_time;
        logic [15:0] edge_timeout;
    } swsr_cfg_t;

    typedef struct packed {
        logic [1:0] line_control;
        logic       busy;
        logic       done;
        logic       response_ok;
        logic [7:0] data_byte;
    } swsr_res_t;

endpackage

`default_nettype wire

// File: rtl/core/swsr_cfg.sv
`default_nettype none

module swsr_cfg
    import swsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output swsr_cfg_t        cfg
);

    swsr_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_time    <= START_LOW_RST;
            cfg_reg.start_high_time   <= START_HIGH_RST;
            cfg_reg.answer_wait_time  <= ANSWER_WAIT_RST;
            cfg_reg.answer_check_time <= ANSWER_CHECK_RST;
            cfg_reg.bit_sample_time   <= BIT_SAMPLE_RST;
            cfg_reg.edge_timeout      <= EDGE_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_START_LOW:    cfg_reg.start_low_time    <= pwdata[15:0];
                REG_START_HIGH:   cfg_reg.start_high_time   <= pwdata[15:0];
                REG_ANSWER_WAIT:  cfg_reg.answer_wait_time  <= pwdata[15:0];
                REG_ANSWER_CHECK: cfg_reg.answer_check_time <= pwdata[15:0];
                REG_BIT_SAMPLE:   cfg_reg.bit_sample_time   <= pwdata[15:0];
                REG_EDGE_TIMEOUT: cfg_reg.edge_timeout      <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START_LOW:    prdata = {16'd0, cfg_reg.start_low_time};
            REG_START_HIGH:   prdata = {16'd0, cfg_reg.start_high_time};
            REG_ANSWER_WAIT:  prdata = {16'd0, cfg_reg.answer_wait_time};
            REG_ANSWER_CHECK: prdata = {16'd0, cfg_reg.answer_check_time};
            REG_BIT_SAMPLE:   prdata = {16'd0, cfg_reg.bit_sample_time};
            REG_EDGE_TIMEOUT: prdata = {16'd0, cfg_reg.edge_timeout};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/swsr_seq.sv
`default_nettype none

module swsr_seq
    import swsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       tick_en,
    input  wire logic [1:0] mode,
    input  wire logic       line_level,
    input  wire swsr_cfg_t  cfg,
    output swsr_res_t       res
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_START_HIGH = 4'd2,
        PH_ANS_WAIT   = 4'd3,
        PH_ANS_CHECK  = 4'd4,
        PH_FALL_WAIT  = 4'd5,
        PH_RD_RISE    = 4'd6,
        PH_RD_SAMPLE  = 4'd7,
        PH_RD_FALL    = 4'd8
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [15:0] time_count_reg, time_count_next;
    logic [2:0]  bit_index_reg,  bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        answer_reg,     answer_next;
    logic        done;
    logic [15:0] count_inc;

    assign count_inc = time_count_reg + 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        time_count_next = count_inc;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        answer_next     = answer_reg;
        done            = 1'b0;

        unique case (phase_reg)
            PH_START_LOW:
            begin
                if (count_inc >= cfg.start_low_time)
                begin
                    phase_next      = PH_START_HIGH;
                    time_count_next = 16'd0;
                end
            end
            PH_START_HIGH:
            begin
                if (count_inc >= cfg.start_high_time)
                begin
                    phase_next      = PH_ANS_WAIT;
                    time_count_next = 16'd0;
                end
            end
            PH_ANS_WAIT:
            begin
                if (count_inc >= cfg.answer_wait_time)
                begin
                    // no low answer skips the high check
                    phase_next      = line_level ? PH_FALL_WAIT : PH_ANS_CHECK;
                    time_count_next = 16'd0;
                end
            end
            PH_ANS_CHECK:
            begin
                if (count_inc >= cfg.answer_check_time)
                begin
                    if (line_level)
                    begin
                        answer_next = 1'b1;
                    end
                    phase_next      = PH_FALL_WAIT;
                    time_count_next = 16'd0;
                end
            end
            PH_FALL_WAIT:
            begin
                if (!line_level || count_inc >= cfg.edge_timeout)
                begin
                    phase_next      = PH_IDLE;
                    time_count_next = 16'd0;
                    done            = 1'b1;
                end
            end
            PH_RD_RISE:
            begin
                // timeout samples the bit anyway
                if (line_level || count_inc >= cfg.edge_timeout)
                begin
                    phase_next      = PH_RD_SAMPLE;
                    time_count_next = 16'd0;
                end
            end
            PH_RD_SAMPLE:
            begin
                if (count_inc >= cfg.bit_sample_time)
                begin
                    shift_byte_next[3'd7 - bit_index_reg] = line_level;
                    phase_next      = PH_RD_FALL;
                    time_count_next = 16'd0;
                end
            end
            PH_RD_FALL:
            begin
                if (!line_level || count_inc >= cfg.edge_timeout)
                begin
                    time_count_next = 16'd0;
                    if (bit_index_reg == 3'd7)
                    begin
                        phase_next     = PH_IDLE;
                        bit_index_next = 3'd0;
                        done           = 1'b1;
                    end
                    else
                    begin
                        phase_next     = PH_RD_RISE;
                        bit_index_next = bit_index_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                phase_next      = PH_IDLE;
                time_count_next = time_count_reg;
                if (mode == MODE_START)
                begin
                    answer_next     = 1'b0;
                    phase_next      = PH_START_LOW;
                    time_count_next = 16'd0;
                end
                else if (mode == MODE_READ)
                begin
                    shift_byte_next = 8'd0;
                    bit_index_next  = 3'd0;
                    phase_next      = PH_RD_RISE;
                    time_count_next = 16'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            time_count_reg <= 16'd0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            answer_reg     <= 1'b0;
        end
        else if (tick_en)
        begin
            phase_reg      <= phase_next;
            time_count_reg <= time_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            answer_reg     <= answer_next;
        end
    end

    // outputs reflect the state after this tick
    always_comb
    begin
        if (phase_next == PH_START_LOW)
        begin
            res.line_control = LINE_DRIVE_LOW;
        end
        else if (phase_next == PH_START_HIGH)
        begin
            res.line_control = LINE_DRIVE_HIGH;
        end
        else
        begin
            res.line_control = LINE_RELEASE;
        end
        res.busy        = (phase_next != PH_IDLE);
        res.done        = done;
        res.response_ok = answer_next;
        res.data_byte   = shift_byte_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/single_wire_sensor_receiver.sv
`default_nettype none

// Master-side sequencer for a single-wire temperature and humidity sensor.
// Every input beat is one microsecond tick carrying the sampled data line
// level and an optional command (start sequence or byte read); every accepted
// beat yields exactly one output beat with the line driver code, busy and done
// flags, the answer flag of the last start and the byte being assembled.
// A tick is accepted every clock unless stalled; the sequencer step is
// combinational logic feeding the output register, so the rate is one
// beat per cycle, and a new tick is taken while the previous result waits as
// long as the output side is not stalled. Timing registers sit on the APB
// port at byte addresses 0x00..0x14 and are to be written only while idle.

module single_wire_sensor_receiver
    import swsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // tick channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic        line_level,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  line_control,
    output logic             busy_res,
    output logic             done_res,
    output logic             response_ok,
    output logic      [7:0]  data_byte,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    swsr_cfg_t cfg;
    swsr_res_t res;
    swsr_res_t res_reg;
    logic      out_valid_reg;
    logic      in_accept;

    // timing registers
    swsr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stall only while a result is held and the consumer is stalled
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // one sequencer step per accepted tick
    swsr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (in_accept),
        .mode       (mode),
        .line_level (line_level),
        .cfg        (cfg),
        .res        (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_control = res_reg.line_control;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign response_ok  = res_reg.response_ok;
    assign data_byte    = res_reg.data_byte;

endmodule

`default_nettype wire
